[hdl/sir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir_pkg
// Widths, reset values, register codes and cell payload types for the
// segment intersection and range block.
// ----------------------------------------------------------------------------
package sir_pkg;

  localparam int CW      = 24;           // coordinate width
  localparam int FB      = 12;           // fraction bits
  localparam int DW      = CW + 1;       // coordinate difference
  localparam int PW      = 2 * CW;       // coordinate product
  localparam int PRE_W   = PW + 1;       // cross term of one segment
  localparam int DET_W   = 2 * DW + 1;   // determinant
  localparam int PP_W    = CW + 1 + DW;  // partial product of a numerator
  localparam int NUM_W   = PRE_W + DW + 1;
  localparam int QB      = CW + 1;       // quotient bits kept
  localparam int DEN_W   = 2 * CW + 2;   // determinant magnitude
  localparam int RB      = DW;           // root bits
  localparam int RAD_W   = 2 * RB;       // radicand
  localparam int REM_W   = RB + 2;       // root remainder

  localparam logic [CW-1:0] MIN_RST = CW'(((1 << FB) + 5) / 10);
  localparam logic [CW-1:0] MAX_RST = CW'(((8 << FB) + 5) / 10);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX = CFG_IDX_W'(1);

  // one restoring division step
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    low;
    logic [QB-1:0]    quo;
    logic [DEN_W-1:0] den;
  } div_t;

  // one square root digit step
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [RB-1:0]    root;
    logic [RAD_W-1:0] rad;
  } sqr_t;

  // bounding box overlap and ray start
  typedef struct packed {
    logic signed [CW-1:0] lox;
    logic signed [CW-1:0] hix;
    logic signed [CW-1:0] loy;
    logic signed [CW-1:0] hiy;
    logic signed [CW-1:0] x3;
    logic signed [CW-1:0] y3;
  } bnd_t;

  // travels beside the divider cells
  typedef struct packed {
    logic detz;
    logic ovx;
    logic ovy;
    logic negx;
    logic negy;
    bnd_t bnd;
  } sb_t;

  // travels beside the root cells
  typedef struct packed {
    logic          hit;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
  } hc_t;

endpackage

[hdl/sir_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir_div_cell
// One restoring division step: shifts in a numerator bit, yields one
// quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module sir_div_cell import sir_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t d_i,
  output div_t d_o
);

  logic [DEN_W:0] sh;
  logic           ge;
  div_t           cell_nxt;
  div_t           cell_r;

  always_comb begin
    sh = {d_i.rem, d_i.low[QB-1]};
    ge = (sh >= {1'b0, d_i.den});
    cell_nxt.den = d_i.den;
    cell_nxt.low = {d_i.low[QB-2:0], 1'b0};
    cell_nxt.quo = {d_i.quo[QB-2:0], ge};
    // without a subtract the shifted value is already below den
    cell_nxt.rem = ge ? DEN_W'(sh - {1'b0, d_i.den}) : sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_o = cell_r;

endmodule

[hdl/sir_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir_sqrt_cell
// One digit of an integer square root: takes two radicand bits, yields
// one root bit and hands the remainder to the next cell.
// ----------------------------------------------------------------------------
module sir_sqrt_cell import sir_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sqr_t d_i,
  output sqr_t d_o
);

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             ge;
  sqr_t             cell_nxt;
  sqr_t             cell_r;

  always_comb begin
    rem2  = {d_i.rem, d_i.rad[RAD_W-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    ge    = (rem2 >= trial);
    cell_nxt.rem  = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
    cell_nxt.root = {d_i.root[RB-2:0], ge};
    cell_nxt.rad  = {d_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_o = cell_r;

endmodule

[hdl/segment_intersection_range.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_range
// Wall / ray segment intersection with crossing point, distance from the
// ray start and a range gate. Fully pipelined row of divider and root cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_ready  wall and ray end points
//  out_      output     out_valid/out_ready hit, crossing, range, in_range
//  cfg_      input      cfg_we             min / max range registers
//
//  One item per cycle while results are taken; 5 front stages, 25 divider cells
//  (x and y side by side), 4 middle stages, 25 root cells, output register.
//  The whole pipeline advances together; it holds while the output register
//  carries a result not yet taken, and in_ready drops for that time.
//  Reset clears the valid bits and loads the range registers.
// ----------------------------------------------------------------------------
module segment_intersection_range import sir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_wall_ax,
  input  logic signed [CW-1:0] in_wall_ay,
  input  logic signed [CW-1:0] in_wall_bx,
  input  logic signed [CW-1:0] in_wall_by,
  input  logic signed [CW-1:0] in_ray_ax,
  input  logic signed [CW-1:0] in_ray_ay,
  input  logic signed [CW-1:0] in_ray_bx,
  input  logic signed [CW-1:0] in_ray_by,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_cross_x,
  output logic signed [CW-1:0] out_cross_y,
  output logic [CW-1:0]        out_range_to_hit,
  output logic                 out_in_range,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CW-1:0]        cfg_wdata
);

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic en;
  logic out_valid_r;

  // ---------------- configuration ----------------
  logic [CW-1:0] min_r, max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RST;
      max_r <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN: min_r <= cfg_wdata;
        CFG_MAX: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- valid line ----------------
  logic [4:0]    vf_r;
  logic [QB-1:0] vd_r;
  logic [3:0]    vm_r;
  logic [RB-1:0] vs_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r        <= '0;
      vd_r        <= '0;
      vm_r        <= '0;
      vs_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vf_r        <= {vf_r[3:0], in_valid};
      vd_r        <= {vd_r[QB-2:0], vf_r[4]};
      vm_r        <= {vm_r[2:0], vd_r[QB-1]};
      vs_r        <= {vs_r[RB-2:0], vm_r[3]};
      out_valid_r <= vs_r[RB-1];
    end
  end

  // ---------------- stage 1: differences, corner products, boxes ----------------
  logic signed [DW-1:0] dx12_1_r, dy12_1_r, dx34_1_r, dy34_1_r;
  logic signed [PW-1:0] pxa_1_r, pxb_1_r, pya_1_r, pyb_1_r;
  bnd_t                 bnd_1_r, bnd_nxt;

  always_comb begin
    bnd_nxt.lox = smax(smin(in_wall_ax, in_wall_bx), smin(in_ray_ax, in_ray_bx));
    bnd_nxt.hix = smin(smax(in_wall_ax, in_wall_bx), smax(in_ray_ax, in_ray_bx));
    bnd_nxt.loy = smax(smin(in_wall_ay, in_wall_by), smin(in_ray_ay, in_ray_by));
    bnd_nxt.hiy = smin(smax(in_wall_ay, in_wall_by), smax(in_ray_ay, in_ray_by));
    bnd_nxt.x3  = in_ray_ax;
    bnd_nxt.y3  = in_ray_ay;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx12_1_r <= DW'(in_wall_ax) - DW'(in_wall_bx);
      dy12_1_r <= DW'(in_wall_ay) - DW'(in_wall_by);
      dx34_1_r <= DW'(in_ray_ax) - DW'(in_ray_bx);
      dy34_1_r <= DW'(in_ray_ay) - DW'(in_ray_by);
      pxa_1_r  <= in_wall_ax * in_wall_by;
      pxb_1_r  <= in_wall_ay * in_wall_bx;
      pya_1_r  <= in_ray_ax * in_ray_by;
      pyb_1_r  <= in_ray_ay * in_ray_bx;
      bnd_1_r  <= bnd_nxt;
    end
  end

  // ---------------- stage 2: determinant products, cross terms ----------------
  logic signed [2*DW-1:0]  m1_2_r, m2_2_r;
  logic signed [PRE_W-1:0] pre_2_r, post_2_r;
  logic signed [DW-1:0]    dx12_2_r, dy12_2_r, dx34_2_r, dy34_2_r;
  bnd_t                    bnd_2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_2_r   <= dx12_1_r * dy34_1_r;
      m2_2_r   <= dy12_1_r * dx34_1_r;
      pre_2_r  <= PRE_W'(pxa_1_r) - PRE_W'(pxb_1_r);
      post_2_r <= PRE_W'(pya_1_r) - PRE_W'(pyb_1_r);
      dx12_2_r <= dx12_1_r;
      dy12_2_r <= dy12_1_r;
      dx34_2_r <= dx34_1_r;
      dy34_2_r <= dy34_1_r;
      bnd_2_r  <= bnd_1_r;
    end
  end

  // ---------------- stage 3: numerator partial products ----------------
  logic signed [CW:0]      pre_lo, pre_hi, post_lo, post_hi;
  logic signed [DET_W-1:0] det_3_r;
  logic signed [PP_W-1:0]  axl_3_r, axh_3_r, bxl_3_r, bxh_3_r;
  logic signed [PP_W-1:0]  ayl_3_r, ayh_3_r, byl_3_r, byh_3_r;
  bnd_t                    bnd_3_r;

  // cross terms split into an unsigned low half and a signed high half
  assign pre_lo  = $signed({1'b0, pre_2_r[CW-1:0]});
  assign pre_hi  = $signed(pre_2_r[PRE_W-1:CW]);
  assign post_lo = $signed({1'b0, post_2_r[CW-1:0]});
  assign post_hi = $signed(post_2_r[PRE_W-1:CW]);

  always_ff @(posedge clk) begin
    if (en) begin
      det_3_r <= DET_W'(m1_2_r) - DET_W'(m2_2_r);
      axl_3_r <= pre_lo * dx34_2_r;
      axh_3_r <= pre_hi * dx34_2_r;
      bxl_3_r <= post_lo * dx12_2_r;
      bxh_3_r <= post_hi * dx12_2_r;
      ayl_3_r <= pre_lo * dy34_2_r;
      ayh_3_r <= pre_hi * dy34_2_r;
      byl_3_r <= post_lo * dy12_2_r;
      byh_3_r <= post_hi * dy12_2_r;
      bnd_3_r <= bnd_2_r;
    end
  end

  // ---------------- stage 4: numerators ----------------
  logic signed [NUM_W-1:0] numx_4_r, numy_4_r;
  logic signed [DET_W-1:0] det_4_r;
  bnd_t                    bnd_4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      numx_4_r <= (NUM_W'(axh_3_r) <<< CW) + NUM_W'(axl_3_r)
                - (NUM_W'(bxh_3_r) <<< CW) - NUM_W'(bxl_3_r);
      numy_4_r <= (NUM_W'(ayh_3_r) <<< CW) + NUM_W'(ayl_3_r)
                - (NUM_W'(byh_3_r) <<< CW) - NUM_W'(byl_3_r);
      det_4_r  <= det_3_r;
      bnd_4_r  <= bnd_3_r;
    end
  end

  // ---------------- stage 5: magnitudes and signs ----------------
  logic [NUM_W-1:0] nxm_5_r, nym_5_r;
  logic [DEN_W-1:0] dm_5_r;
  logic             negx_5_r, negy_5_r, detz_5_r;
  bnd_t             bnd_5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nxm_5_r  <= numx_4_r[NUM_W-1] ? NUM_W'(-numx_4_r) : NUM_W'(numx_4_r);
      nym_5_r  <= numy_4_r[NUM_W-1] ? NUM_W'(-numy_4_r) : NUM_W'(numy_4_r);
      dm_5_r   <= det_4_r[DET_W-1] ? DEN_W'(-det_4_r) : DEN_W'(det_4_r);
      negx_5_r <= numx_4_r[NUM_W-1] ^ det_4_r[DET_W-1];
      negy_5_r <= numy_4_r[NUM_W-1] ^ det_4_r[DET_W-1];
      detz_5_r <= (det_4_r == '0);
      bnd_5_r  <= bnd_4_r;
    end
  end

  // ---------------- divider cells ----------------
  // Only the low QB quotient bits are formed; a larger quotient lies
  // outside every box and is flagged instead.
  div_t dx_c [QB+1];
  div_t dy_c [QB+1];
  sb_t  sb_nxt;
  sb_t  sbd_r [QB];

  always_comb begin
    dx_c[0].rem = nxm_5_r[NUM_W-1:QB];
    dx_c[0].low = nxm_5_r[QB-1:0];
    dx_c[0].quo = '0;
    dx_c[0].den = dm_5_r;
    dy_c[0].rem = nym_5_r[NUM_W-1:QB];
    dy_c[0].low = nym_5_r[QB-1:0];
    dy_c[0].quo = '0;
    dy_c[0].den = dm_5_r;
    sb_nxt.detz = detz_5_r;
    sb_nxt.ovx  = (nxm_5_r[NUM_W-1:QB] >= dm_5_r);
    sb_nxt.ovy  = (nym_5_r[NUM_W-1:QB] >= dm_5_r);
    sb_nxt.negx = negx_5_r;
    sb_nxt.negy = negy_5_r;
    sb_nxt.bnd  = bnd_5_r;
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    sir_div_cell u_dx (.clk(clk), .en(en), .d_i(dx_c[i]), .d_o(dx_c[i+1]));
    sir_div_cell u_dy (.clk(clk), .en(en), .d_i(dy_c[i]), .d_o(dy_c[i+1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbd_r[0] <= sb_nxt;
      for (int k = 1; k < QB; k++) begin
        sbd_r[k] <= sbd_r[k-1];
      end
    end
  end

  // ---------------- stage 7: signed quotient, box test ----------------
  logic signed [QB:0]   qx, qy;
  logic                 hit_nxt;
  sb_t                  sbq;
  hc_t                  hc_7_r;
  logic signed [CW-1:0] x3_7_r, y3_7_r;

  always_comb begin
    sbq = sbd_r[QB-1];
    qx  = sbq.negx ? -$signed({1'b0, dx_c[QB].quo}) : $signed({1'b0, dx_c[QB].quo});
    qy  = sbq.negy ? -$signed({1'b0, dy_c[QB].quo}) : $signed({1'b0, dy_c[QB].quo});
    hit_nxt = !sbq.detz && !sbq.ovx && !sbq.ovy
           && (qx >= sbq.bnd.lox) && (qx <= sbq.bnd.hix)
           && (qy >= sbq.bnd.loy) && (qy <= sbq.bnd.hiy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hc_7_r.hit <= hit_nxt;
      hc_7_r.cx  <= qx[CW-1:0];
      hc_7_r.cy  <= qy[CW-1:0];
      x3_7_r     <= sbq.bnd.x3;
      y3_7_r     <= sbq.bnd.y3;
    end
  end

  // ---------------- stages 8..10: offset, squares, sum ----------------
  logic signed [DW-1:0]   ex_8_r, ey_8_r;
  logic signed [2*DW-1:0] sqx_9_r, sqy_9_r;
  logic [RAD_W-1:0]       sum_10_r;
  hc_t                    hc_8_r, hc_9_r, hc_10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ex_8_r   <= DW'($signed(hc_7_r.cx)) - DW'(x3_7_r);
      ey_8_r   <= DW'($signed(hc_7_r.cy)) - DW'(y3_7_r);
      hc_8_r   <= hc_7_r;
      sqx_9_r  <= ex_8_r * ex_8_r;
      sqy_9_r  <= ey_8_r * ey_8_r;
      hc_9_r   <= hc_8_r;
      sum_10_r <= RAD_W'(sqx_9_r) + RAD_W'(sqy_9_r);
      hc_10_r  <= hc_9_r;
    end
  end

  // ---------------- root cells ----------------
  sqr_t sq_c [RB+1];
  hc_t  hcs_r [RB];

  always_comb begin
    sq_c[0].rem  = '0;
    sq_c[0].root = '0;
    sq_c[0].rad  = sum_10_r;
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    sir_sqrt_cell u_sq (.clk(clk), .en(en), .d_i(sq_c[j]), .d_o(sq_c[j+1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hcs_r[0] <= hc_10_r;
      for (int k = 1; k < RB; k++) begin
        hcs_r[k] <= hcs_r[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  logic [RB-1:0] root;
  logic [CW-1:0] rng;
  hc_t           hco;
  logic          hit_r, in_range_r;
  logic [CW-1:0] cx_r, cy_r, rng_r;

  always_comb begin
    root = sq_c[RB].root;
    hco  = hcs_r[RB-1];
    rng  = root[RB-1] ? '1 : root[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r      <= hco.hit;
      cx_r       <= hco.hit ? hco.cx : '0;
      cy_r       <= hco.hit ? hco.cy : '0;
      rng_r      <= hco.hit ? rng : '0;
      in_range_r <= hco.hit && (rng > min_r) && (rng < max_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_cross_x      = $signed(cx_r);
  assign out_cross_y      = $signed(cy_r);
  assign out_range_to_hit = rng_r;
  assign out_in_range     = in_range_r;

endmodule

[hdl/sir_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir_chk
// Port-level checks for segment_intersection_range, bound to the top level.
// ----------------------------------------------------------------------------
module sir_chk import sir_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_hit,
  input logic signed [CW-1:0] out_cross_x,
  input logic signed [CW-1:0] out_cross_y,
  input logic [CW-1:0]        out_range_to_hit,
  input logic                 out_in_range
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_cross_x) && $stable(out_cross_y)
      && $stable(out_range_to_hit) && $stable(out_in_range))
    else $error("stalled result changed");

  // a blocked output stalls the input side too
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output blocked");

  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0
      && out_range_to_hit == '0 && !out_in_range)
    else $error("miss with nonzero fields");

  // strict bounds exclude zero and full scale
  a_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |-> out_hit && out_range_to_hit != '0
      && out_range_to_hit != '1)
    else $error("in_range inconsistent");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_intersection_range sir_chk u_sir_chk (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_range. Drives wall / ray
// segment pairs through the valid/ready channel, predicts hit, crossing
// point, distance and range flag with wide exact arithmetic, and compares
// every result transfer in order. Covers parallel and degenerate segments,
// extreme coordinates, distance saturation, several range settings,
// random idling on both sides, a long receiver stall and a full drain.
// ----------------------------------------------------------------------------
module tb;
  import sir_pkg::*;

  localparam int LIMIT     = 600000;
  localparam int DRAIN_CYC = 80;
  localparam int N_RANDOM  = 1450;

  typedef struct packed {
    logic signed [CW-1:0] wax, way, wbx, wby, rax, ray, rbx, rby;
  } seg_pair_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] rng;
    logic          in_rng;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_wall_ax = '0, in_wall_ay = '0, in_wall_bx = '0, in_wall_by = '0;
  logic signed [CW-1:0] in_ray_ax = '0, in_ray_ay = '0, in_ray_bx = '0, in_ray_by = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [CW-1:0] out_cross_x, out_cross_y;
  logic [CW-1:0] out_range_to_hit;
  logic out_in_range;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MIN;
  logic [CW-1:0] cfg_wdata = '0;

  logic [CW-1:0] range_lo = MIN_RST;
  logic [CW-1:0] range_hi = MAX_RST;

  hit_rec_t expected_hits[$];
  int  mismatches = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_hits = 0;
  int  n_in_range = 0;
  int  cycles = 0;
  int  stall_cycles = 0;
  bit  steady = 1'b0;   // no idling on either side while set

  segment_intersection_range uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: long hold-off, steady stretch, or random stalls
  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      out_ready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 32);
    end
  end

  // result checker
  always @(posedge clk) begin
    hit_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        want = expected_hits.pop_front();
        if (out_hit) n_hits++;
        if (out_in_range) n_in_range++;
        if (out_hit !== want.hit || out_cross_x !== want.cx || out_cross_y !== want.cy ||
            out_range_to_hit !== want.rng || out_in_range !== want.in_rng) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b x=%h y=%h r=%h in=%0b  got hit=%0b x=%h y=%h r=%h in=%0b",
                     want.hit, want.cx, want.cy, want.rng, want.in_rng,
                     out_hit, out_cross_x, out_cross_y, out_range_to_hit, out_in_range);
        end
      end
    end
  end

  function automatic logic signed [127:0] lo2(logic signed [127:0] a, logic signed [127:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [127:0] hi2(logic signed [127:0] a, logic signed [127:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic hit_rec_t predict_hit(seg_pair_t s);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] det, pre, post, qx, qy, ex, ey, sum, cand, root;
    hit_rec_t r;
    x1 = s.wax; y1 = s.way; x2 = s.wbx; y2 = s.wby;
    x3 = s.rax; y3 = s.ray; x4 = s.rbx; y4 = s.rby;
    r = '0;
    det = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    if (det == 0) return r;
    pre  = x1 * y2 - y1 * x2;
    post = x3 * y4 - y3 * x4;
    qx = (pre * (x3 - x4) - (x1 - x2) * post) / det;
    qy = (pre * (y3 - y4) - (y1 - y2) * post) / det;
    if (qx < lo2(x1, x2) || qx > hi2(x1, x2) || qx < lo2(x3, x4) || qx > hi2(x3, x4) ||
        qy < lo2(y1, y2) || qy > hi2(y1, y2) || qy < lo2(y3, y4) || qy > hi2(y3, y4))
      return r;
    ex = qx - x3;
    ey = qy - y3;
    sum = ex * ex + ey * ey;
    root = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = root | (128'sd1 << b);
      if (cand * cand <= sum) root = cand;
    end
    if (root > 128'sd16777215) root = 128'sd16777215;
    r.hit = 1'b1;
    r.cx = qx[CW-1:0];
    r.cy = qy[CW-1:0];
    r.rng = root[CW-1:0];
    r.in_rng = (r.rng > range_lo) && (r.rng < range_hi);
    return r;
  endfunction

  task automatic send_pair(seg_pair_t s);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_wall_ax <= s.wax; in_wall_ay <= s.way; in_wall_bx <= s.wbx; in_wall_by <= s.wby;
    in_ray_ax <= s.rax; in_ray_ay <= s.ray; in_ray_bx <= s.rbx; in_ray_by <= s.rby;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_hits.insert(expected_hits.size(), predict_hit(s));
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_range(logic [CW-1:0] lo, logic [CW-1:0] hi);
    wait_idle();
    cfg_we <= 1'b1; cfg_idx <= CFG_MIN; cfg_wdata <= lo;
    @(posedge clk);
    cfg_idx <= CFG_MAX; cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    range_lo = lo;
    range_hi = hi;
  endtask

  function automatic logic signed [CW-1:0] rnd_scaled(int k);
    int v;
    v = $signed($urandom) >>> (31 - k);
    return v[CW-1:0];
  endfunction

  // mostly crossing pairs built around a chosen point, plus noise
  function automatic seg_pair_t make_pair();
    seg_pair_t s;
    int k, sel, px, py, ux, uy, vx, vy;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return s;
    end
    k = $urandom_range(6, 20);
    px = rnd_scaled(20); py = rnd_scaled(20);
    ux = rnd_scaled(k); uy = rnd_scaled(k);
    vx = rnd_scaled(k); vy = rnd_scaled(k);
    s.wax = CW'(px + ux); s.way = CW'(py + uy);
    s.wbx = CW'(px - ux * $urandom_range(1, 3)); s.wby = CW'(py - uy * $urandom_range(1, 3));
    s.rax = CW'(px - vx); s.ray = CW'(py - vy);
    if (sel < 25) begin
      // ray along the offset to the first wall end; parallel to the wall when both scale factors match
      s.rbx = CW'(s.rax + ux); s.rby = CW'(s.ray + uy);
    end else if (sel < 30) begin
      s.rbx = s.rax; s.rby = s.ray;
    end else begin
      s.rbx = CW'(px + vx * $urandom_range(1, 3)); s.rby = CW'(py + vy * $urandom_range(1, 3));
    end
    return s;
  endfunction

  task automatic test_directed();
    localparam logic signed [CW-1:0] PMAX = 24'sh7FFFFF;
    localparam logic signed [CW-1:0] PMIN = -24'sh800000;
    // parallel, collinear, degenerate
    send_pair('{0, 0, 4096, 0, 0, 4096, 4096, 4096});
    send_pair('{0, 0, 4096, 0, 1024, 0, 8192, 0});
    send_pair('{100, 100, 100, 100, 100, 100, 100, 100});
    send_pair('{0, 0, 0, 0, -4096, 0, 4096, 0});
    // plain crossing, distances near the default gate
    send_pair('{2048, -4096, 2048, 4096, 0, 0, 8192, 0});
    send_pair('{410, -4096, 410, 4096, 0, 0, 8192, 0});
    send_pair('{411, -4096, 411, 4096, 0, 0, 8192, 0});
    send_pair('{3277, -4096, 3277, 4096, 0, 0, 8192, 0});
    send_pair('{3276, -4096, 3276, 4096, 0, 0, 8192, 0});
    // crossing at the ray start, and at a segment end point
    send_pair('{0, -4096, 0, 4096, 0, 0, 8192, 0});
    send_pair('{4096, 0, 4096, 4096, 0, 0, 4096, 0});
    // bounding box just missed
    send_pair('{9000, -4096, 9000, 4096, 0, 0, 8192, 0});
    // extreme coordinates and saturated distance
    send_pair('{PMIN, PMAX, PMAX, PMIN, PMIN, PMIN, PMAX, PMAX});
    send_pair('{PMAX, PMIN, PMAX, PMAX, PMIN, 0, PMAX, 0});
    send_pair('{PMIN, PMIN, PMAX, PMAX, PMIN, PMAX, PMAX, PMIN});
    send_pair('{PMAX, PMAX, PMIN, PMIN, PMAX, PMIN, PMIN, PMAX});
    send_pair('{-1, -1, 1, 1, -1, 1, 1, -1});
    send_pair('{PMIN, 0, PMAX, 0, 0, PMIN, 0, PMAX});
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 3) && (i < n / 3 + 120);
      send_pair(make_pair());
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    stall_cycles <= 300;
    for (int i = 0; i < 120; i++) send_pair(make_pair());
  endtask

  task automatic test_drain();
    for (int i = 0; i < 20; i++) send_pair(make_pair());
    wait_idle();
    for (int i = 0; i < 20; i++) send_pair(make_pair());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(N_RANDOM / 4);
    write_range('0, 24'hFFFFFF);
    test_directed();
    test_random(N_RANDOM / 4);
    write_range(24'hFFFFFF, '0);
    test_random(N_RANDOM / 8);
    write_range(CW'($urandom_range(0, 4096)), CW'($urandom_range(4096, 1 << 20)));
    test_backpressure();
    test_random(N_RANDOM / 4);
    write_range(24'd2000, 24'd900000);
    test_drain();
    test_random(N_RANDOM / 8);
    wait_idle();
    $display("covered %0d segment pairs, %0d results checked, %0d hits, %0d in range",
             n_sent, n_checked, n_hits, n_in_range);
    $display("range settings: reset, wide open, inverted, random, fixed; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
